[sv/radius_query_entity_scan_top_macros.svh]
// Assertion macros shared by the RTL of the radius query entity scan block.
`ifndef RADIUS_QUERY_ENTITY_SCAN_TOP_MACROS_SVH
`define RADIUS_QUERY_ENTITY_SCAN_TOP_MACROS_SVH

// Checked at every clock edge outside of reset.
`define RQES_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define RQES_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[sv/rqes_pkg.sv]
// Package with the types, codes and constants of the radius query entity scan block.
`default_nettype none

package rqes_pkg;

  localparam int unsigned ENTITY_SLOTS_DEF = 1024;
  localparam int unsigned OUT_IDX_W        = 10;
  localparam int unsigned TEAM_W           = 8;
  localparam int unsigned COORD_W          = 32;
  localparam int unsigned RADIUS_W         = 31;
  localparam int unsigned DIFF_W           = 32;
  localparam int unsigned PROD_W           = 64;
  localparam int unsigned SUM_W            = 66;
  localparam int unsigned RSQ_W            = 62;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_FREE  = 2'd1,
    OP_QUERY = 2'd2,
    OP_NEXT  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_CTR,
    S_RSQ,
    S_EVAL,
    S_SQ,
    S_CMP,
    S_EMIT
  } state_e;

  typedef enum logic [1:0] {
    MUL_RADIUS,
    MUL_DX,
    MUL_DY,
    MUL_DZ
  } mul_sel_e;

  typedef struct packed {
    logic [TEAM_W-1:0]         team;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } ent_t;

  typedef struct packed {
    logic     load_diff;
    logic     mul_en;
    mul_sel_e mul_sel;
    logic     acc_load;
    logic     acc_add;
    logic     rsq_load;
  } dist_ctrl_t;

endpackage

`default_nettype wire

[sv/rqes_req_if.sv]
// Request channel interface of the radius query entity scan block.
`default_nettype none

interface rqes_req_if
  import rqes_pkg::*;
;
  logic                      valid;
  logic                      ready;
  op_e                       operation;
  logic [OUT_IDX_W-1:0]      entity_index;
  logic [TEAM_W-1:0]         team_id;
  logic signed [COORD_W-1:0] pos_x;
  logic signed [COORD_W-1:0] pos_y;
  logic signed [COORD_W-1:0] pos_z;
  logic [RADIUS_W-1:0]       radius;

  modport source (
    output valid, operation, entity_index, team_id, pos_x, pos_y, pos_z, radius,
    input  ready
  );

  modport sink (
    input  valid, operation, entity_index, team_id, pos_x, pos_y, pos_z, radius,
    output ready
  );
endinterface

`default_nettype wire

[sv/rqes_rsp_if.sv]
// Result channel interface of the radius query entity scan block.
`default_nettype none

interface rqes_rsp_if
  import rqes_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic [OUT_IDX_W-1:0] match_count;
  logic [OUT_IDX_W-1:0] found_entity;
  logic                 found_flag;

  modport source (
    output valid, match_count, found_entity, found_flag,
    input  ready
  );

  modport sink (
    input  valid, match_count, found_entity, found_flag,
    output ready
  );
endinterface

`default_nettype wire

[sv/rqes_dist_unit.sv]
// Shared squared-distance unit: one multiplier, an accumulator and the radius compare.
`default_nettype none

module rqes_dist_unit
  import rqes_pkg::*;
(
  input  logic                clk_i,
  input  dist_ctrl_t          ctrl_i,
  input  logic [RADIUS_W-1:0] radius_i,
  input  ent_t                entity_i,
  input  ent_t                center_i,
  output logic                within_o
);

  function automatic logic [DIFF_W-1:0] abs_diff(logic signed [COORD_W-1:0] a,
                                                 logic signed [COORD_W-1:0] b);
    logic signed [COORD_W:0] d;
    d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
    return d[COORD_W] ? DIFF_W'(-d) : DIFF_W'(d);
  endfunction

  logic [DIFF_W-1:0] dx_q, dy_q, dz_q;
  logic [DIFF_W-1:0] mul_a;
  logic [PROD_W-1:0] prod_q;
  logic [SUM_W-1:0]  acc_q;
  logic [RSQ_W-1:0]  rsq_q;

  always_comb begin
    case (ctrl_i.mul_sel)
      MUL_RADIUS: mul_a = DIFF_W'(radius_i);
      MUL_DX:     mul_a = dx_q;
      MUL_DY:     mul_a = dy_q;
      MUL_DZ:     mul_a = dz_q;
      default:    mul_a = dx_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_diff) begin
      dx_q <= abs_diff(entity_i.x, center_i.x);
      dy_q <= abs_diff(entity_i.y, center_i.y);
      dz_q <= abs_diff(entity_i.z, center_i.z);
    end
    if (ctrl_i.mul_en) begin
      prod_q <= PROD_W'(mul_a) * PROD_W'(mul_a);
    end
    if (ctrl_i.acc_load) begin
      acc_q <= SUM_W'(prod_q);
    end else if (ctrl_i.acc_add) begin
      acc_q <= acc_q + SUM_W'(prod_q);
    end
    if (ctrl_i.rsq_load) begin
      rsq_q <= prod_q[RSQ_W-1:0];
    end
  end

  assign within_o = (acc_q + SUM_W'(prod_q)) <= SUM_W'(rsq_q);

endmodule

`default_nettype wire

[sv/radius_query_entity_scan_top.sv]
// Top level of the radius query entity scan block: entity table, match list and sequencer.
//
// Requests arrive on req_i and each one gives exactly one result on rsp_o.
// A write stores team and position of an entity and marks it valid; a free
// clears the valid mark; a query scans the table for entries of another team
// within the radius of the center entity; a next returns the matches in order.
// Write, free and next go from acceptance straight to the emit state.
// A query first loads the center entity and squares the radius, then reads
// the table one slot at a time; each valid entry of another team is then
// squared axis by axis on the single shared multiplier and compared.
// A query whose center index lies beyond the table goes straight to emit.
// The block works on one request at a time; req_i.ready is high only when idle.
// After reset the valid marks are cleared by a pass over every slot,
// during which no request is accepted.
// The result sits in an output register; while the receiver stalls it holds,
// and the block may accept the next request but will not finish it until the
// register is free.
`default_nettype none
`include "radius_query_entity_scan_top_macros.svh"

module radius_query_entity_scan_top
  import rqes_pkg::*;
#(
  parameter int unsigned ENTITY_SLOTS = ENTITY_SLOTS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  rqes_req_if.sink   req_i,
  rqes_rsp_if.source rsp_o
);

  localparam int unsigned IdxW = (ENTITY_SLOTS > 1) ? $clog2(ENTITY_SLOTS) : 1;
  localparam int unsigned CntW = $clog2(ENTITY_SLOTS + 1);
  localparam logic [IdxW-1:0] LastSlot = IdxW'(ENTITY_SLOTS - 1);

  state_e state_q, state_d;

  ent_t                 ent_mem [ENTITY_SLOTS];
  logic                 val_mem [ENTITY_SLOTS];
  logic [OUT_IDX_W-1:0] ml_mem  [ENTITY_SLOTS];
  ent_t                 ent_rd_q;
  logic                 val_rd_q;
  logic [OUT_IDX_W-1:0] ml_rd_q;

  op_e                 op_q;
  logic [IdxW-1:0]     center_q;
  logic [RADIUS_W-1:0] radius_q;
  ent_t                ctr_q;

  logic [IdxW-1:0] scan_q, scan_d;
  logic [IdxW-1:0] clr_q, clr_d;
  logic [CntW-1:0] held_q, held_d;
  logic [CntW-1:0] cursor_q, cursor_d;
  logic [1:0]      step_q, step_d;

  logic                 rsp_valid_q, rsp_valid_d;
  logic [OUT_IDX_W-1:0] rsp_count_q;
  logic [OUT_IDX_W-1:0] rsp_found_q;
  logic                 rsp_flag_q;

  logic            accept;
  logic            in_range;
  logic [IdxW-1:0] req_idx;
  logic [IdxW-1:0] ent_raddr;
  logic            val_we;
  logic [IdxW-1:0] val_waddr;
  logic            val_wdata;
  logic            ml_we;
  logic            load_ctr;
  logic            rsp_load;
  logic            next_hit;
  logic            in_radius;
  dist_ctrl_t      dctrl;

  assign req_i.ready = (state_q == S_IDLE);
  assign accept      = req_i.valid && req_i.ready;
  assign in_range    = 32'(req_i.entity_index) < ENTITY_SLOTS;
  assign req_idx     = IdxW'(req_i.entity_index);
  assign ent_raddr   = (state_q == S_IDLE) ? req_idx : scan_d;
  assign next_hit    = (op_q == OP_NEXT) && (cursor_q < held_q);

  assign val_we    = (state_q == S_CLEAR) ||
                     (accept && in_range &&
                      (req_i.operation == OP_WRITE || req_i.operation == OP_FREE));
  assign val_waddr = (state_q == S_CLEAR) ? clr_q : req_idx;
  assign val_wdata = (state_q != S_CLEAR) && (req_i.operation == OP_WRITE);

  always_ff @(posedge clk_i) begin
    if (accept && in_range && req_i.operation == OP_WRITE) begin
      ent_mem[req_idx] <= '{team: req_i.team_id, x: req_i.pos_x,
                            y: req_i.pos_y, z: req_i.pos_z};
    end
    ent_rd_q <= ent_mem[ent_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (val_we) begin
      val_mem[val_waddr] <= val_wdata;
    end
    val_rd_q <= val_mem[scan_d];
  end

  always_ff @(posedge clk_i) begin
    if (ml_we) begin
      ml_mem[held_q[IdxW-1:0]] <= OUT_IDX_W'(scan_q);
    end
    ml_rd_q <= ml_mem[cursor_q[IdxW-1:0]];
  end

  rqes_dist_unit u_dist (
    .clk_i    (clk_i),
    .ctrl_i   (dctrl),
    .radius_i (radius_q),
    .entity_i (ent_rd_q),
    .center_i (ctr_q),
    .within_o (in_radius)
  );

  always_comb begin
    state_d  = state_q;
    scan_d   = scan_q;
    clr_d    = clr_q;
    held_d   = held_q;
    cursor_d = cursor_q;
    step_d   = step_q;
    dctrl    = '0;
    ml_we    = 1'b0;
    load_ctr = 1'b0;
    rsp_load = 1'b0;
    case (state_q)
      S_CLEAR: begin
        clr_d = clr_q + 1'b1;
        if (clr_q == LastSlot) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          if (req_i.operation == OP_QUERY) begin
            held_d   = '0;
            cursor_d = '0;
            scan_d   = '0;
            state_d  = in_range ? S_CTR : S_EMIT;
          end else begin
            state_d = S_EMIT;
          end
        end
      end
      S_CTR: begin
        load_ctr      = 1'b1;
        dctrl.mul_en  = 1'b1;
        dctrl.mul_sel = MUL_RADIUS;
        state_d       = S_RSQ;
      end
      S_RSQ: begin
        dctrl.rsq_load = 1'b1;
        state_d        = S_EVAL;
      end
      S_EVAL: begin
        if (val_rd_q && scan_q != center_q && ent_rd_q.team != ctr_q.team) begin
          dctrl.load_diff = 1'b1;
          step_d          = '0;
          state_d         = S_SQ;
        end else if (scan_q == LastSlot) begin
          state_d = S_EMIT;
        end else begin
          scan_d = scan_q + 1'b1;
        end
      end
      S_SQ: begin
        dctrl.mul_en = 1'b1;
        step_d       = step_q + 1'b1;
        case (step_q)
          2'd0: begin
            dctrl.mul_sel = MUL_DX;
          end
          2'd1: begin
            dctrl.mul_sel  = MUL_DY;
            dctrl.acc_load = 1'b1;
          end
          default: begin
            dctrl.mul_sel = MUL_DZ;
            dctrl.acc_add = 1'b1;
            state_d       = S_CMP;
          end
        endcase
      end
      S_CMP: begin
        if (in_radius) begin
          ml_we  = 1'b1;
          held_d = held_q + 1'b1;
        end
        if (scan_q == LastSlot) begin
          state_d = S_EMIT;
        end else begin
          scan_d  = scan_q + 1'b1;
          state_d = S_EVAL;
        end
      end
      S_EMIT: begin
        if (!rsp_valid_q || rsp_o.ready) begin
          rsp_load = 1'b1;
          state_d  = S_IDLE;
          if (next_hit) begin
            cursor_d = cursor_q + 1'b1;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (rsp_load) begin
      rsp_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_d = 1'b0;
    end else begin
      rsp_valid_d = rsp_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q      <= '0;
      clr_q       <= '0;
      held_q      <= '0;
      cursor_q    <= '0;
      step_q      <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      scan_q      <= scan_d;
      clr_q       <= clr_d;
      held_q      <= held_d;
      cursor_q    <= cursor_d;
      step_q      <= step_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q     <= req_i.operation;
      center_q <= req_idx;
      radius_q <= req_i.radius;
    end
    if (load_ctr) begin
      ctr_q <= ent_rd_q;
    end
    if (rsp_load) begin
      rsp_count_q <= OUT_IDX_W'(held_q);
      rsp_found_q <= next_hit ? ml_rd_q : '0;
      rsp_flag_q  <= next_hit;
    end
  end

  assign rsp_o.valid        = rsp_valid_q;
  assign rsp_o.match_count  = rsp_count_q;
  assign rsp_o.found_entity = rsp_found_q;
  assign rsp_o.found_flag   = rsp_flag_q;

  `RQES_ASSERT(a_cursor_le_held, cursor_q <= held_q, "Read cursor passed the match count.")
  `RQES_ASSERT(a_held_in_table, held_q < CntW'(ENTITY_SLOTS), "Match count exceeds table.")
  `RQES_ASSERT(a_match_counted,
               (state_q == S_CMP && in_radius) |=> (held_q == CntW'($past(held_q) + 1'b1)),
               "A match was not counted.")
  `RQES_ASSERT(a_scan_step,
               (state_q == S_EVAL && $past(state_q) == S_EVAL) |->
                 (scan_q == IdxW'($past(scan_q) + 1'b1)),
               "Scan skipped or repeated a slot.")
  `RQES_ASSERT(a_rsp_from_emit, $rose(rsp_o.valid) |-> ($past(state_q) == S_EMIT),
               "Result raised outside of emit.")

endmodule

`default_nettype wire
